FILE: hdl/assert_macros.svh
// Assertion macros used by the back end RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check an implication property on every rising clock edge outside reset.
`define CSM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define CSM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CSM_ASSERT(lbl, clk, rstn, prop)
`define CSM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: hdl/csm_pkg.sv
// Types, constants and arithmetic helpers of the sparse matrix-vector block.
package csm_pkg;

  localparam int VECTOR_DEPTH_DEF = 4096;
  localparam int IDX_W            = 12;
  localparam int VAL_W            = 32;
  localparam int ACC_W            = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int APB_ADDR_W       = 3;

  localparam logic [VAL_W-1:0] SCALE_RESET = 32'h0001_0000;

  // Register index carried in paddr[2]
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] Q_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] Q_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_NZ,
    CMD_CLOSE
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_CLAMP,
    ST_MUL,
    ST_FINISH
  } st_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             idx_ok;
    logic             closes;
    logic             last;
  } cmd_t;

  // Saturating signed 64-bit add
  function automatic logic [ACC_W-1:0] sat_add64(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // Arithmetic shift right by 16, then saturate to signed 32 bits
  function automatic logic [VAL_W-1:0] shr16_sat32(logic [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:47]) | ~(|v[ACC_W-1:47]);
    if (!fits) begin
      return v[ACC_W-1] ? Q_MIN : Q_MAX;
    end
    return v[47:16];
  endfunction

endpackage

FILE: hdl/csr_sparse_matvec.sv
// A nonzero with row end passes READ, ACC, CLAMP, MUL and FINISH, an empty row CLAMP, MUL and
// FINISH; the result is registered as FINISH is left, and queued commands ahead of it run first.
// A load is written in IDLE and a nonzero without row end passes READ and ACC. The back end takes
// a new command only in IDLE; the shared multiplier steps set this, and a held result stalls it.
// A two-entry command queue lets the input run ahead while a result waits to be taken.
// Reset (rst_ni, asynchronous, active low) clears accumulators, row counter and registers.
module csr_sparse_matvec import csm_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // [11:0] index, [43:12] value, [47:44] zero
  input  logic [2:0]            s_axis_tuser,  // [1:0] opcode, [2] row_end
  input  logic                  s_axis_tlast,  // matrix_end
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [79:0]           m_axis_tdata,  // [11:0] row_index, [75:12] result_value, [79:76] zero
  output logic [0:0]            m_axis_tuser,  // [0] result_kind
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [VAL_W-1:0] scale_q;
  logic             energy_q;
  logic             cfg_write;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic             out_kind;
  logic [IDX_W-1:0] out_row;
  logic [ACC_W-1:0] out_value;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      energy_q <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SCALE) begin
        scale_q <= pwdata;
      end else begin
        energy_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, energy_q} : scale_q;

  csm_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser[1:0]),
    .index_i      (s_axis_tdata[11:0]),
    .value_i      (s_axis_tdata[43:12]),
    .row_end_i    (s_axis_tuser[2]),
    .matrix_end_i (s_axis_tlast),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  csm_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .scale_i     (scale_q),
    .energy_i    (energy_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_row_o   (out_row),
    .out_value_o (out_value)
  );

  assign m_axis_tdata = {4'b0, out_value, out_row};
  assign m_axis_tuser = out_kind;

endmodule

FILE: hdl/csm_ram.sv
// Generic RAM: one write port, two registered read ports.
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/csm_front.sv
// Front end: accepts stream requests, classifies them and queues commands.
module csm_front import csm_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             row_end_i,
  input  logic             matrix_end_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  cmd_t          cmd_new;
  logic          keep;
  logic          push;
  logic          pop;
  logic          idx_ok;

  // Classify the incoming request
  always_comb begin
    idx_ok         = (32'(index_i) < VECTOR_DEPTH);
    cmd_new.index  = index_i;
    cmd_new.value  = value_i;
    cmd_new.idx_ok = idx_ok;
    cmd_new.kind   = CMD_LOAD;
    cmd_new.closes = 1'b0;
    cmd_new.last   = 1'b0;
    keep           = 1'b0;
    case (opcode_i)
      OP_LOAD: begin
        cmd_new.kind = CMD_LOAD;
        keep         = idx_ok;
      end
      OP_NZ: begin
        cmd_new.kind   = CMD_NZ;
        cmd_new.closes = row_end_i;
        cmd_new.last   = row_end_i & matrix_end_i;
        keep           = 1'b1;
      end
      OP_EMPTY: begin
        cmd_new.kind   = CMD_CLOSE;
        cmd_new.closes = 1'b1;
        cmd_new.last   = matrix_end_i;
        keep           = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (count_q != CW'(QUEUE_DEPTH));
  assign push        = in_valid_i & in_ready_o & keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: hdl/csm_back.sv
// Back end: executes commands with one shared multiplier and holds the result.
`include "assert_macros.svh"

module csm_back import csm_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic [VAL_W-1:0] scale_i,
  input  logic             energy_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_kind_o,
  output logic [IDX_W-1:0] out_row_o,
  output logic [ACC_W-1:0] out_value_o
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  st_e              st_q, st_d;
  cmd_t             cmd_q;
  logic [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [VAL_W-1:0] q_q;
  logic [ACC_W-1:0] norm_q;
  logic [IDX_W-1:0] row_q;
  logic             out_valid_q;
  logic             out_kind_q;
  logic [IDX_W-1:0] out_row_q;
  logic [ACC_W-1:0] out_value_q;

  logic [AW+IDX_W-1:0] col_wide;
  logic [AW+IDX_W-1:0] row_wide;
  logic [AW-1:0]       col_addr;
  logic [AW-1:0]       row_addr;
  logic                we;
  logic                re;
  logic [VAL_W-1:0]    x_col_raw;
  logic [VAL_W-1:0]    x_row_raw;
  logic [VAL_W-1:0]    x_col;
  logic [VAL_W-1:0]    x_row;
  logic                row_ok;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [VAL_W-1:0] mul_b;
  logic signed [ACC_W-1:0] mul_p;
  logic                load_prod;
  logic                need_out;
  logic                out_free;
  logic                advance;
  logic [ACC_W-1:0]    acc_sum;
  logic [ACC_W-1:0]    norm_sum;
  logic [VAL_W-1:0]    prod_q32;

  // Vector store addressing
  assign col_wide = {{AW{1'b0}}, cmd_i.index};
  assign row_wide = {{AW{1'b0}}, row_q};
  assign col_addr = col_wide[AW-1:0];
  assign row_addr = row_wide[AW-1:0];

  csm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (col_addr),
    .wdata_i   (cmd_i.value),
    .re_a_i    (re),
    .raddr_a_i (col_addr),
    .rdata_a_o (x_col_raw),
    .re_b_i    (re),
    .raddr_b_i (row_addr),
    .rdata_b_o (x_row_raw)
  );

  // Out-of-range reads yield zero
  assign row_ok = (32'(row_q) < VECTOR_DEPTH);
  assign x_col  = cmd_q.idx_ok ? x_col_raw : '0;
  assign x_row  = row_ok ? x_row_raw : '0;

  assign acc_sum  = sat_add64(acc_q, prod_q);
  assign norm_sum = sat_add64(norm_q, prod_q);
  assign prod_q32 = shr16_sat32(prod_q);
  assign mul_p    = mul_a * mul_b;

  assign need_out = ~energy_i | cmd_q.last;
  assign out_free = ~out_valid_q | out_ready_i;
  assign advance  = (st_q == ST_FINISH) & (~need_out | out_free);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_NZ:    st_d = ST_READ;
            CMD_CLOSE: st_d = ST_CLAMP;
            default:   st_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   st_d = ST_ACC;
      ST_ACC:    st_d = cmd_q.closes ? ST_CLAMP : ST_IDLE;
      ST_CLAMP:  st_d = ST_MUL;
      ST_MUL:    st_d = ST_FINISH;
      ST_FINISH: st_d = advance ? ST_IDLE : ST_FINISH;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    load_prod = 1'b0;
    mul_a     = $signed(q_q);
    mul_b     = energy_i ? $signed(x_row) : $signed(scale_i);
    case (st_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        we        = cmd_valid_i & (cmd_i.kind == CMD_LOAD);
        re        = cmd_valid_i & (cmd_i.kind != CMD_LOAD);
      end
      ST_READ: begin
        mul_a     = $signed(cmd_q.value);
        mul_b     = $signed(x_col);
        load_prod = 1'b1;
      end
      ST_MUL: begin
        load_prod = 1'b1;
      end
      default: begin
        load_prod = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      acc_q       <= '0;
      norm_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      // Accumulate the row, clear it once the row sum is taken
      if (st_q == ST_ACC) begin
        acc_q <= acc_sum;
      end else if (st_q == ST_CLAMP) begin
        acc_q <= '0;
      end
      // Close the row
      if (advance) begin
        row_q  <= cmd_q.last ? '0 : row_q + 1'b1;
        norm_q <= cmd_q.last ? '0 : (energy_i ? norm_sum : norm_q);
      end
      // Hold the result until taken
      if (advance && need_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (load_prod) begin
      prod_q <= mul_p;
    end
    if (st_q == ST_CLAMP) begin
      q_q <= shr16_sat32(acc_q);
    end
    if (advance && need_out) begin
      out_kind_q  <= energy_i;
      out_row_q   <= row_q;
      out_value_q <= energy_i ? norm_sum : {{(ACC_W-VAL_W){prod_q32[VAL_W-1]}}, prod_q32};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_row_o   = out_row_q;
  assign out_value_o = out_value_q;

  `CSM_ASSERT(a_pop_idle, clk_i, rst_ni, cmd_pop_o |-> (st_q == ST_IDLE))
  `CSM_ASSERT(a_acc_cleared, clk_i, rst_ni, (st_q == ST_CLAMP) |=> (acc_q == '0))
  `CSM_ASSERT(a_stall_holds, clk_i, rst_ni, ((st_q == ST_FINISH) && need_out && out_valid_q && !out_ready_i) |=> (st_q == ST_FINISH))
  `CSM_ASSERT(a_matrix_end, clk_i, rst_ni, (advance && cmd_q.last) |=> ((row_q == '0) && (norm_q == '0)))
  `CSM_ASSERT_NEVER(a_no_pop_busy, clk_i, rst_ni, cmd_pop_o && (st_q != ST_IDLE))

endmodule
